// ===== src/marker_framed_control_deframer_top_assert.svh =====
// Assertion macros used by the sequencer module (mfcd_emit_seq).
`ifndef MARKER_FRAMED_CONTROL_DEFRAMER_TOP_ASSERT_SVH
`define MARKER_FRAMED_CONTROL_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mfcd_pkg.sv =====
`default_nettype none

package mfcd_pkg;

   // Marker bytes of the serial framing.
   localparam logic [7:0] START_MARK = 8'd255;
   localparam logic [7:0] END_MARK   = 8'd254;

   // Request operation codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_PEDAL   = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // Fixed field and counter widths.
   localparam int LEVEL_W   = 10;
   localparam int INDEX_W   = 4;
   localparam int COUNT_W   = 6;
   localparam int QUIET_W   = 17;
   localparam int TIMEOUT_W = 16;
   localparam logic [QUIET_W-1:0] QUIET_MAX = {QUIET_W{1'b1}};

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] index;
      logic [LEVEL_W-1:0] level;
      logic               pressed;
      logic               override_active;
      logic               last;
   } rsp_type;

   // Work handed from the frame parser to the output sequencer.
   typedef struct packed {
      logic run_items;
      logic run_status;
   } run_cmd_type;

endpackage

`default_nettype wire

// ===== src/mfcd_frame_ram.sv =====
`default_nettype none

module mfcd_frame_ram #(
   parameter int DEPTH  = 35,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output      logic [7:0]        rd_data_a,
   output      logic [7:0]        rd_data_b
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports, read every cycle.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== src/mfcd_level_unit.sv =====
`default_nettype none

module mfcd_level_unit (
   input  wire logic [7:0]                  data_byte,
   output      logic [mfcd_pkg::LEVEL_W-1:0] level
);

   localparam int VW = mfcd_pkg::LEVEL_W + 1;
   localparam logic [VW-1:0] CAP = {1'b0, {mfcd_pkg::LEVEL_W{1'b1}}};

   logic [VW-1:0] shifted;
   logic [VW-1:0] sat;
   logic [16:0]   wide;

   // Scale the byte into the level range and clip at full scale.
   always_comb begin
      shifted = VW'(data_byte) << (mfcd_pkg::LEVEL_W - 7);
      sat     = (shifted > CAP) ? CAP : shifted;
      wide    = 17'(sat);
      level   = wide[mfcd_pkg::LEVEL_W-1:0];
   end

endmodule

`default_nettype wire

// ===== src/mfcd_rx_parser.sv =====
`default_nettype none

module mfcd_rx_parser #(
   parameter int PAYLOAD     = 35,
   parameter int FRAME_LIMIT = 48,
   parameter int ADDR_W      = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_fire,
   input  wire mfcd_pkg::req_type               req_data,
   input  wire logic                            csr_fire,
   input  wire logic [mfcd_pkg::TIMEOUT_W-1:0]  csr_data,
   output      logic                            wr_en,
   output      logic [ADDR_W-1:0]               wr_addr,
   output      logic [7:0]                      wr_data,
   output      mfcd_pkg::run_cmd_type           cmd,
   output      logic                            override_flag
);

   localparam logic [mfcd_pkg::COUNT_W-1:0] PAYLOAD_C = mfcd_pkg::COUNT_W'(PAYLOAD);
   localparam logic [mfcd_pkg::COUNT_W-1:0] LIMIT_C   = mfcd_pkg::COUNT_W'(FRAME_LIMIT);

   logic                            in_frame_ff,   in_frame_in;
   logic [mfcd_pkg::COUNT_W-1:0]    count_ff,      count_in;
   logic                            override_ff,   override_in;
   logic [mfcd_pkg::QUIET_W-1:0]    quiet_ff,      quiet_in;
   logic [mfcd_pkg::TIMEOUT_W-1:0]  timeout_ff,    timeout_in;
   logic                            mode_nz_ff,    mode_nz_in;
   logic [7:0]                      rx;

   // Frame tracking, quiet timer and override decisions for one request.
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      override_in = override_ff;
      quiet_in    = quiet_ff;
      mode_nz_in  = mode_nz_ff;
      timeout_in  = csr_fire ? csr_data : timeout_ff;
      cmd         = '0;
      rx          = req_data.rx_byte;
      wr_en       = 1'b0;
      wr_addr     = count_ff[ADDR_W-1:0];
      wr_data     = rx;
      if (req_fire) begin
         if (req_data.operation == mfcd_pkg::OP_TICK) begin
            quiet_in = (quiet_ff < mfcd_pkg::QUIET_MAX) ? quiet_ff + 1'b1 : quiet_ff;
            if ((timeout_ff != '0) && override_ff && (quiet_in > {1'b0, timeout_ff})) begin
               override_in    = 1'b0;
               cmd.run_status = 1'b1;
            end
         end else if (!in_frame_ff) begin
            if (rx == mfcd_pkg::START_MARK) begin
               in_frame_in = 1'b1;
               count_in    = '0;
            end
         end else if (rx == mfcd_pkg::END_MARK) begin
            // Full frame with nonzero first byte: applied. Else status only; a full one also clears override.
            if ((count_ff >= PAYLOAD_C) && mode_nz_ff) begin
               override_in   = 1'b1;
               cmd.run_items = 1'b1;
            end else begin
               if (count_ff >= PAYLOAD_C) begin
                  override_in = 1'b0;
               end
               cmd.run_status = 1'b1;
            end
            quiet_in    = '0;
            in_frame_in = 1'b0;
         end else if (rx == mfcd_pkg::START_MARK) begin
            count_in = '0;
         end else if (count_ff < LIMIT_C) begin
            if (count_ff < PAYLOAD_C) begin
               wr_en = 1'b1;
               if (count_ff == '0) begin
                  mode_nz_in = (rx != 8'd0);
               end
            end
            count_in = count_ff + 1'b1;
         end else begin
            // An overlong frame is dropped.
            in_frame_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         override_ff <= 1'b0;
         quiet_ff    <= '0;
         timeout_ff  <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         override_ff <= override_in;
         quiet_ff    <= quiet_in;
         timeout_ff  <= timeout_in;
      end
      mode_nz_ff <= mode_nz_in;
   end

   assign override_flag = override_ff;

endmodule

`default_nettype wire

// ===== src/mfcd_emit_seq.sv =====
`default_nettype none

`include "marker_framed_control_deframer_top_assert.svh"

module mfcd_emit_seq #(
   parameter int CHANNELS = 16,
   parameter int PEDALS   = 2,
   parameter int ADDR_W   = 6
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mfcd_pkg::run_cmd_type        cmd_i,
   input  wire logic                         override_i,
   input  wire logic [7:0]                   button_byte,
   input  wire logic [mfcd_pkg::LEVEL_W-1:0] level_i,
   output      logic [ADDR_W-1:0]            rd_addr_a,
   output      logic [ADDR_W-1:0]            rd_addr_b,
   output      logic                         busy,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      mfcd_pkg::rsp_type            rsp_data
);

   localparam int ITEMS  = CHANNELS + PEDALS;
   localparam int ITEM_W = $clog2(ITEMS);
   localparam logic [ITEM_W-1:0] LAST_IDX = ITEM_W'(ITEMS - 1);
   localparam logic [ITEM_W-1:0] CH_C     = ITEM_W'(CHANNELS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_STATUS
   } state_type;

   state_type           state_ff,     state_in;
   logic [ITEM_W-1:0]   item_idx_ff,  item_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mfcd_pkg::rsp_type   rsp_data_ff,  rsp_data_in;
   logic                slot_free;
   logic                is_chan;

   // Store addresses of the current item's level and button bytes.
   always_comb begin
      is_chan   = item_idx_ff < CH_C;
      rd_addr_b = ADDR_W'(CHANNELS + 1) + ADDR_W'(item_idx_ff);
      rd_addr_a = is_chan ? ADDR_W'(1) + ADDR_W'(item_idx_ff) : rd_addr_b;
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: per item ST_READ, ST_LOAD (waits for a free slot); then the status item. Status-only runs skip items.
   always_comb begin
      state_in     = state_ff;
      item_idx_in  = item_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            item_idx_in = '0;
            if (cmd_i.run_items) begin
               state_in = ST_READ;
            end else if (cmd_i.run_status) begin
               state_in = ST_STATUS;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.kind             = is_chan ? mfcd_pkg::KIND_CHANNEL
                                                      : mfcd_pkg::KIND_PEDAL;
               rsp_data_in.index            = is_chan ? mfcd_pkg::INDEX_W'(item_idx_ff)
                                                      : mfcd_pkg::INDEX_W'(item_idx_ff - CH_C);
               rsp_data_in.level            = level_i;
               rsp_data_in.pressed          = is_chan && (button_byte != 8'd0);
               rsp_data_in.override_active  = override_i;
               rsp_data_in.last             = 1'b0;
               if (item_idx_ff == LAST_IDX) begin
                  state_in = ST_STATUS;
               end else begin
                  item_idx_in = item_idx_ff + 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_STATUS: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.kind            = mfcd_pkg::KIND_STATUS;
               rsp_data_in.override_active = override_i;
               rsp_data_in.last            = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         item_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         item_idx_ff  <= item_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer.
   `MFCD_ASSERT_SAME(a_cmd_only_idle, clock, reset, cmd_i.run_items || cmd_i.run_status, state_ff == ST_IDLE, "run command while sequencer busy")
   `MFCD_ASSERT_NEXT(a_run_sets_override, clock, reset, cmd_i.run_items, override_i, "item run without override set")
   `MFCD_ASSERT_SAME(a_idx_in_range, clock, reset, state_ff != ST_IDLE, item_idx_ff <= LAST_IDX, "item index past last item")
   `MFCD_ASSERT_NEXT(a_status_ends_run, clock, reset, (state_ff == ST_STATUS) && slot_free, (state_ff == ST_IDLE) && rsp_valid_ff && rsp_data_ff.last, "status item did not end the run")

endmodule

`default_nettype wire

// ===== src/marker_framed_control_deframer_top.sv =====
// A byte or tick that causes no result leaves the sequencer idle, so the next request can follow at once.
// A status-only request sends the sequencer to ST_STATUS, which registers the status item as the result.
// An applied frame emits CHANNELS+PEDALS items, then the status item: each item passes a store read state
// (ST_READ) and an output load state (ST_LOAD), and a result held by rsp_stall keeps the sequencer waiting.
// Reset (synchronous, active high) clears frame, override, timer and timeout; the frame
// store is left as is and needs no clearing pass, so requests are taken right after reset.
`default_nettype none

module marker_framed_control_deframer_top #(
   parameter int CHANNELS    = 16,
   parameter int PEDALS      = 2,
   parameter int FRAME_LIMIT = 48
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire mfcd_pkg::req_type               req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      mfcd_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [mfcd_pkg::TIMEOUT_W-1:0]  csr_data
);

   localparam int PAYLOAD = 1 + 2 * CHANNELS + PEDALS;
   localparam int ADDR_W  = $clog2(PAYLOAD);

   logic                          req_fire;
   logic                          busy;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [7:0]                    wr_data;
   logic [ADDR_W-1:0]             rd_addr_a;
   logic [ADDR_W-1:0]             rd_addr_b;
   logic [7:0]                    rd_data_a;
   logic [7:0]                    rd_data_b;
   logic [mfcd_pkg::LEVEL_W-1:0]  level;
   logic                          override_flag;
   mfcd_pkg::run_cmd_type         cmd;

   // Requests are taken only while no run is in progress.
   assign req_stall = busy;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   mfcd_rx_parser #(
      .PAYLOAD     (PAYLOAD),
      .FRAME_LIMIT (FRAME_LIMIT),
      .ADDR_W      (ADDR_W)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_data      (req_data),
      .csr_fire      (csr_valid && csr_ready),
      .csr_data      (csr_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .cmd           (cmd),
      .override_flag (override_flag)
   );

   mfcd_frame_ram #(
      .DEPTH  (PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mfcd_level_unit u_level (
      .data_byte (rd_data_a),
      .level     (level)
   );

   mfcd_emit_seq #(
      .CHANNELS (CHANNELS),
      .PEDALS   (PEDALS),
      .ADDR_W   (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .override_i  (override_flag),
      .button_byte (rd_data_b),
      .level_i     (level),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
